FILE: design/hsl2rgb_pkg.sv
// hsl2rgb_pkg: shared widths and constants for the hsl to rgb converter
// depends on nothing; imported by every module of the converter
package hsl2rgb_pkg;

    // width of the hue, saturation and lightness input fields
    localparam int FIELD_W = 17;

    // width of one colour channel byte
    localparam int BYTE_W = 8;

    // default number of fractional bits in the input fields
    localparam int FRAC_BITS_DEF = 16;

    // largest channel byte
    localparam logic [BYTE_W-1:0] BYTE_MAX = '1;

endpackage

FILE: design/hsl_to_rgb_convert_unit.sv
// hsl_to_rgb_convert_unit: top level of the hsl to rgb colour converter
// depends on hsl2rgb_pkg, hsl2rgb_prep and hsl2rgb_mix
//
//   side   | handshake            | payload
//   -------+----------------------+-----------------------------------------
//   input  | i_valid / o_stall    | i_hue, i_saturation, i_lightness (17 b)
//   output | o_valid / i_stall    | o_red, o_green, o_blue (8 b)
//
// five register stages, the last being the output register; one item is
// taken every cycle unless a stall has backed up to the input
// stalls ripple back stage by stage; empty stages keep filling, so items are
// still taken while a finished result waits at the output
// reset clears the stage valid bits only; there is no other state
module hsl_to_rgb_convert_unit import hsl2rgb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [FIELD_W-1:0] i_hue,
    input  logic [FIELD_W-1:0] i_saturation,
    input  logic [FIELD_W-1:0] i_lightness,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [BYTE_W-1:0]  o_red,
    output logic [BYTE_W-1:0]  o_green,
    output logic [BYTE_W-1:0]  o_blue
);

    // links between the two halves of the pipeline
    logic               prep_ready;
    logic               prep_valid;
    logic               mix_ready;
    logic [FRAC_BITS:0] p_val, d_val;
    logic [FRAC_BITS:0] w_red, w_green, w_blue;
    logic               grey;
    logic [BYTE_W-1:0]  grey_byte;

    assign o_stall = !prep_ready;

    // clamp, products, q and p, ramp weights
    hsl2rgb_prep #(
        .FRAC_BITS(FRAC_BITS)
    ) u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (prep_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_lightness  (i_lightness),
        .o_valid      (prep_valid),
        .i_ready      (mix_ready),
        .o_p          (p_val),
        .o_d          (d_val),
        .o_w_red      (w_red),
        .o_w_green    (w_green),
        .o_w_blue     (w_blue),
        .o_grey       (grey),
        .o_grey_byte  (grey_byte)
    );

    // channel products and byte scaling
    hsl2rgb_mix #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (prep_valid),
        .o_ready     (mix_ready),
        .i_p         (p_val),
        .i_d         (d_val),
        .i_w_red     (w_red),
        .i_w_green   (w_green),
        .i_w_blue    (w_blue),
        .i_grey      (grey),
        .i_grey_byte (grey_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

endmodule

FILE: design/hsl2rgb_prep.sv
// hsl2rgb_prep: first three pipeline stages (clamp, l*s, hue ramp weights, q and p)
// depends on hsl2rgb_pkg; instantiated by hsl_to_rgb_convert_unit
module hsl2rgb_prep import hsl2rgb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [FIELD_W-1:0]   i_hue,
    input  logic [FIELD_W-1:0]   i_saturation,
    input  logic [FIELD_W-1:0]   i_lightness,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [FRAC_BITS:0]   o_p,
    output logic [FRAC_BITS:0]   o_d,
    output logic [FRAC_BITS:0]   o_w_red,
    output logic [FRAC_BITS:0]   o_w_green,
    output logic [FRAC_BITS:0]   o_w_blue,
    output logic                 o_grey,
    output logic [BYTE_W-1:0]    o_grey_byte
);

    // value width: 0 up to one inclusive
    localparam int VW = FRAC_BITS + 1;
    // width of the l*s product
    localparam int LW = 2 * VW;
    // width used to compare a raw field against one
    localparam int XW = (FIELD_W > VW) ? FIELD_W : VW;
    // width of six times the hue
    localparam int HW = FIELD_W + 3;
    // signed width of a shifted hue position
    localparam int TW = ((HW > FRAC_BITS + 4) ? HW : FRAC_BITS + 4) + 2;
    // width of the grey scaling
    localparam int GW = VW + BYTE_W;

    localparam logic [VW-1:0]        V_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [VW-1:0]        V_HALF  = {2'b01, {(FRAC_BITS-1){1'b0}}};
    localparam logic [XW-1:0]        X_ONE   = XW'(V_ONE);
    localparam logic [LW-1:0]        L_ROUND = LW'(V_ONE) - LW'(1);
    localparam logic signed [TW-1:0] T_ZERO  = '0;
    localparam logic signed [TW-1:0] T_ONE   = TW'(V_ONE);
    localparam logic signed [TW-1:0] T_TWO   = T_ONE + T_ONE;
    localparam logic signed [TW-1:0] T_THREE = T_TWO + T_ONE;
    localparam logic signed [TW-1:0] T_FOUR  = T_TWO + T_TWO;
    localparam logic signed [TW-1:0] T_SIX   = T_FOUR + T_TWO;

    // saturate a raw field to one
    function automatic logic [VW-1:0] clamp_one(input logic [FIELD_W-1:0] i_x);
        logic [XW-1:0] xe;
        logic [VW-1:0] r;
        xe = XW'(i_x);
        if (xe > X_ONE) begin
            r = V_ONE;
        end else begin
            r = xe[VW-1:0];
        end
        return r;
    endfunction

    // ramp weight in 0..one for a hue position in sixths of a turn, single wrap
    function automatic logic [VW-1:0] hue_weight(input logic signed [TW-1:0] i_t);
        logic signed [TW-1:0] t;
        logic signed [TW-1:0] fall;
        logic [VW-1:0]        w;
        t = i_t;
        if (t < T_ZERO) begin
            t = t + T_SIX;
        end
        if (t > T_SIX) begin
            t = t - T_SIX;
        end
        fall = T_FOUR - t;
        if (t < T_ONE) begin
            w = t[VW-1:0];
        end else if (t < T_THREE) begin
            w = V_ONE;
        end else if (t < T_FOUR) begin
            w = fall[VW-1:0];
        end else begin
            w = '0;
        end
        return w;
    endfunction

    // stage valid bits and ready chain
    logic [3:1] r_vld;
    logic       rdy1, rdy2, rdy3;

    assign rdy3    = !r_vld[3] || i_ready;
    assign rdy2    = !r_vld[2] || rdy3;
    assign rdy1    = !r_vld[1] || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy1) r_vld[1] <= i_valid;
            if (rdy2) r_vld[2] <= r_vld[1];
            if (rdy3) r_vld[3] <= r_vld[2];
        end
    end

    // stage 1: clamp, grey test and six times hue
    logic [VW-1:0] r1_l, r1_s;
    logic [HW-1:0] r1_h6;
    logic          r1_grey;
    logic [VW-1:0] n1_l, n1_s;
    logic [HW-1:0] n1_h6;

    always_comb begin
        n1_l  = clamp_one(i_lightness);
        n1_s  = clamp_one(i_saturation);
        n1_h6 = (HW'(i_hue) << 2) + (HW'(i_hue) << 1);
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_l    <= n1_l;
            r1_s    <= n1_s;
            r1_h6   <= n1_h6;
            r1_grey <= (i_saturation == '0);
        end
    end

    // stage 2: l*s product and the three ramp weights
    logic [LW-1:0]        r2_ls;
    logic [VW-1:0]        r2_l, r2_s;
    logic [VW-1:0]        r2_wr, r2_wg, r2_wb;
    logic                 r2_grey;
    logic [LW-1:0]        n2_ls;
    logic signed [TW-1:0] n2_th;

    always_comb begin
        n2_ls = LW'(r1_l) * LW'(r1_s);
        n2_th = $signed(TW'(r1_h6));
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_ls   <= n2_ls;
            r2_l    <= r1_l;
            r2_s    <= r1_s;
            r2_wr   <= hue_weight(n2_th + T_TWO);
            r2_wg   <= hue_weight(n2_th);
            r2_wb   <= hue_weight(n2_th - T_TWO);
            r2_grey <= r1_grey;
        end
    end

    // stage 3: q, p, q - p and the grey byte
    logic [VW-1:0]     r3_p, r3_d;
    logic [VW-1:0]     r3_wr, r3_wg, r3_wb;
    logic              r3_grey;
    logic [BYTE_W-1:0] r3_gbyte;
    logic [VW-1:0]     n3_fl, n3_ce, n3_q, n3_p;
    logic [VW:0]       n3_qw, n3_pw;
    logic [GW-1:0]     n3_gv, n3_gsh;
    logic [BYTE_W-1:0] n3_gbyte;

    always_comb begin
        n3_fl = VW'(r2_ls >> FRAC_BITS);
        n3_ce = VW'((r2_ls + L_ROUND) >> FRAC_BITS);
        // low lightness: q = l + l*s, otherwise q = l + s - l*s (rounded up)
        if (r2_l < V_HALF) begin
            n3_qw = {1'b0, r2_l} + {1'b0, n3_fl};
        end else begin
            n3_qw = {1'b0, r2_l} + {1'b0, r2_s} - {1'b0, n3_ce};
        end
        n3_q  = n3_qw[VW-1:0];
        n3_pw = {r2_l, 1'b0} - {1'b0, n3_q};
        n3_p  = n3_pw[VW-1:0];
        // grey level is lightness times 255
        n3_gv  = (GW'(r2_l) << BYTE_W) - GW'(r2_l);
        n3_gsh = n3_gv >> FRAC_BITS;
        if (n3_gsh > GW'(BYTE_MAX)) begin
            n3_gbyte = BYTE_MAX;
        end else begin
            n3_gbyte = n3_gsh[BYTE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_p     <= n3_p;
            r3_d     <= n3_q - n3_p;
            r3_wr    <= r2_wr;
            r3_wg    <= r2_wg;
            r3_wb    <= r2_wb;
            r3_grey  <= r2_grey;
            r3_gbyte <= n3_gbyte;
        end
    end

    assign o_p         = r3_p;
    assign o_d         = r3_d;
    assign o_w_red     = r3_wr;
    assign o_w_green   = r3_wg;
    assign o_w_blue    = r3_wb;
    assign o_grey      = r3_grey;
    assign o_grey_byte = r3_gbyte;

endmodule

FILE: design/hsl2rgb_mix.sv
// hsl2rgb_mix: last two pipeline stages (ramp products, byte scaling, output register)
// depends on hsl2rgb_pkg; instantiated by hsl_to_rgb_convert_unit
module hsl2rgb_mix import hsl2rgb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [FRAC_BITS:0] i_p,
    input  logic [FRAC_BITS:0] i_d,
    input  logic [FRAC_BITS:0] i_w_red,
    input  logic [FRAC_BITS:0] i_w_green,
    input  logic [FRAC_BITS:0] i_w_blue,
    input  logic               i_grey,
    input  logic [BYTE_W-1:0]  i_grey_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [BYTE_W-1:0]  o_red,
    output logic [BYTE_W-1:0]  o_green,
    output logic [BYTE_W-1:0]  o_blue
);

    localparam int VW = FRAC_BITS + 1;
    localparam int LW = 2 * VW;
    localparam int SW = LW + BYTE_W;

    // p*one + product, times 255, down to a clamped byte
    function automatic logic [BYTE_W-1:0] to_byte(input logic [VW-1:0] i_pv,
                                                  input logic [LW-1:0] i_prod);
        logic [LW-1:0]     v;
        logic [SW-1:0]     sc;
        logic [SW-1:0]     hi;
        logic [BYTE_W-1:0] b;
        v  = (LW'(i_pv) << FRAC_BITS) + i_prod;
        sc = (SW'(v) << BYTE_W) - SW'(v);
        hi = sc >> (2 * FRAC_BITS);
        if (hi > SW'(BYTE_MAX)) begin
            b = BYTE_MAX;
        end else begin
            b = hi[BYTE_W-1:0];
        end
        return b;
    endfunction

    // stage valid bits and ready chain
    logic r4_vld, r_out_vld;
    logic rdy4, rdy5;

    assign rdy5    = !r_out_vld || !i_stall;
    assign rdy4    = !r4_vld || rdy5;
    assign o_ready = rdy4;
    assign o_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (rdy4) r4_vld    <= i_valid;
            if (rdy5) r_out_vld <= r4_vld;
        end
    end

    // stage 4: (q - p) times each channel weight
    logic [VW-1:0]     r4_p;
    logic [LW-1:0]     r4_pr_red, r4_pr_green, r4_pr_blue;
    logic              r4_grey;
    logic [BYTE_W-1:0] r4_gbyte;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_p        <= i_p;
            r4_pr_red   <= LW'(i_d) * LW'(i_w_red);
            r4_pr_green <= LW'(i_d) * LW'(i_w_green);
            r4_pr_blue  <= LW'(i_d) * LW'(i_w_blue);
            r4_grey     <= i_grey;
            r4_gbyte    <= i_grey_byte;
        end
    end

    // stage 5: channel bytes into the output register
    logic [BYTE_W-1:0] r_red, r_green, r_blue;
    logic [BYTE_W-1:0] n_red, n_green, n_blue;

    always_comb begin
        if (r4_grey) begin
            n_red   = r4_gbyte;
            n_green = r4_gbyte;
            n_blue  = r4_gbyte;
        end else begin
            n_red   = to_byte(r4_p, r4_pr_red);
            n_green = to_byte(r4_p, r4_pr_green);
            n_blue  = to_byte(r4_p, r4_pr_blue);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

FILE: test/tb_hsl_to_rgb_convert_unit.sv
// tb_hsl_to_rgb_convert_unit: self-checking testbench for the hsl to rgb converter
// depends on hsl2rgb_pkg and hsl_to_rgb_convert_unit; drives random and corner colours
// through both handshakes and checks each rgb item against its own fixed-point predictor
`timescale 1ns / 1ps

module tb_hsl_to_rgb_convert_unit import hsl2rgb_pkg::*;;

    // 1.0 in the input fixed-point format
    localparam longint UNITY = 64'sd1 <<< FRAC_BITS_DEF;
    localparam logic [FIELD_W-1:0] LEVEL_ONE = FIELD_W'(UNITY);
    localparam logic [FIELD_W-1:0] LEVEL_TOP = '1;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CHUNK_ITEMS = 100;
    localparam int IDLE_MAX = 6;
    localparam int TAIL_CYCLES = 16;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } t_rgb;

    // predicts each colour and holds the rgb items still owed by the block
    class rgb_scoreboard;
        t_rgb        pending_rgb[$];
        int unsigned n_items;
        int unsigned n_grey;
        int unsigned n_over;
        int unsigned n_checked;
        int unsigned n_errors;

        // one channel byte from the hue ramp at t6 = 6 * hue + offset
        function logic [BYTE_W-1:0] ramp_byte(longint p_lvl, longint q_lvl, longint t6);
            longint v2;
            longint b;
            // single wrap, strict comparisons
            if (t6 < 0)
                t6 += 6 * UNITY;
            if (t6 > 6 * UNITY)
                t6 -= 6 * UNITY;
            if (t6 < UNITY)
                v2 = p_lvl * UNITY + (q_lvl - p_lvl) * t6;
            else if (t6 < 3 * UNITY)
                v2 = q_lvl * UNITY;
            else if (t6 < 4 * UNITY)
                v2 = p_lvl * UNITY + (q_lvl - p_lvl) * (4 * UNITY - t6);
            else
                v2 = p_lvl * UNITY;
            if (v2 <= 0)
                return '0;
            b = (v2 * 255) / (UNITY * UNITY);
            return (b > 255) ? BYTE_MAX : b[BYTE_W-1:0];
        endfunction

        function t_rgb hsl_to_rgb(logic [FIELD_W-1:0] hue, logic [FIELD_W-1:0] sat,
                                  logic [FIELD_W-1:0] lvl);
            longint hv;
            longint sv;
            longint lv;
            longint q2;
            longint q_lvl;
            longint p_lvl;
            longint g;
            t_rgb   c;
            hv = longint'(hue);
            sv = (longint'(sat) > UNITY) ? UNITY : longint'(sat);
            lv = (longint'(lvl) > UNITY) ? UNITY : longint'(lvl);
            // grey when there is no saturation
            if (sv == 0) begin
                g = (lv * 255) / UNITY;
                if (g > 255)
                    g = 255;
                c.red   = g[BYTE_W-1:0];
                c.green = g[BYTE_W-1:0];
                c.blue  = g[BYTE_W-1:0];
                return c;
            end
            if (2 * lv < UNITY)
                q2 = lv * (UNITY + sv);
            else
                q2 = lv * UNITY + sv * UNITY - lv * sv;
            q_lvl = q2 / UNITY;
            p_lvl = 2 * lv - q_lvl;
            c.red   = ramp_byte(p_lvl, q_lvl, 6 * hv + 2 * UNITY);
            c.green = ramp_byte(p_lvl, q_lvl, 6 * hv);
            c.blue  = ramp_byte(p_lvl, q_lvl, 6 * hv - 2 * UNITY);
            return c;
        endfunction

        function void note_item(logic [FIELD_W-1:0] hue, logic [FIELD_W-1:0] sat,
                                logic [FIELD_W-1:0] lvl);
            n_items++;
            if (sat == '0)
                n_grey++;
            if (sat > LEVEL_ONE || lvl > LEVEL_ONE)
                n_over++;
            pending_rgb.push_back(hsl_to_rgb(hue, sat, lvl));
        endfunction

        function void check_result(logic [BYTE_W-1:0] red, logic [BYTE_W-1:0] green,
                                   logic [BYTE_W-1:0] blue);
            t_rgb want;
            if (pending_rgb.size() == 0) begin
                $error("rgb item with nothing expected: %0d %0d %0d", red, green, blue);
                n_errors++;
                return;
            end
            want = pending_rgb.pop_front();
            n_checked++;
            if (red !== want.red) begin
                $error("red: expected %0d, got %0d", want.red, red);
                n_errors++;
            end
            if (green !== want.green) begin
                $error("green: expected %0d, got %0d", want.green, green);
                n_errors++;
            end
            if (blue !== want.blue) begin
                $error("blue: expected %0d, got %0d", want.blue, blue);
                n_errors++;
            end
        endfunction

        function int pending();
            return pending_rgb.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [FIELD_W-1:0] i_hue;
    logic [FIELD_W-1:0] i_saturation;
    logic [FIELD_W-1:0] i_lightness;
    logic               o_valid;
    logic               i_stall;
    logic [BYTE_W-1:0]  o_red;
    logic [BYTE_W-1:0]  o_green;
    logic [BYTE_W-1:0]  o_blue;

    rgb_scoreboard board = new;
    bit            quiet_run = 1'b0;

    hsl_to_rgb_convert_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_lightness  (i_lightness),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // check every rgb item taken at the output
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_red, o_green, o_blue);
    end

    // idle for a random count, then offer one item until it is taken
    task automatic send_item(input logic [FIELD_W-1:0] hue, input logic [FIELD_W-1:0] sat,
                             input logic [FIELD_W-1:0] lvl);
        int gap;
        gap = quiet_run ? 0 : $urandom_range(0, IDLE_MAX);
        repeat (gap) begin
            i_valid      <= 1'b0;
            i_hue        <= FIELD_W'($urandom());
            i_saturation <= FIELD_W'($urandom());
            i_lightness  <= FIELD_W'($urandom());
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_lightness  <= lvl;
        do
            @(posedge i_clk);
        while (o_stall);
        board.note_item(hue, sat, lvl);
    endtask

    // hold the input off until every owed rgb item has come out
    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
    endtask

    // saturation or lightness: mostly in range, with zero, one, edges and over range
    function automatic logic [FIELD_W-1:0] draw_level();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return LEVEL_ONE;
            2:       return FIELD_W'($urandom_range(1, 255));
            3:       return LEVEL_ONE - FIELD_W'($urandom_range(1, 255));
            4:       return FIELD_W'($urandom());
            5:       return LEVEL_ONE / 2 + FIELD_W'($urandom_range(0, 2)) - 1'b1;
            default: return FIELD_W'($urandom_range(0, int'(UNITY)));
        endcase
    endfunction

    // hue: mostly one turn, some near the sixths of a turn, some up to almost two turns
    function automatic logic [FIELD_W-1:0] draw_hue();
        int k;
        k = $urandom_range(0, 6);
        case ($urandom_range(0, 7))
            0:       return FIELD_W'($urandom());
            1, 2:    return FIELD_W'((k * int'(UNITY)) / 6 + $urandom_range(0, 4) - 2 + 2);
            default: return FIELD_W'($urandom_range(0, int'(UNITY)));
        endcase
    endfunction

    // output side: stall for a random count before each item
    initial begin : result_sink
        int hold;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = quiet_run ? 0 : $urandom_range(0, IDLE_MAX);
            repeat (hold) begin
                i_stall <= 1'b1;
                @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do
                @(posedge i_clk);
            while (!o_valid);
        end
    end

    // input side: reset, corner colours, then random colours in chunks
    initial begin : colour_source
        int chunk;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_hue        <= '0;
        i_saturation <= '0;
        i_lightness  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // grey, including clamp of lightness above one
        send_item(0, 0, 0);
        send_item(12345, 0, LEVEL_ONE);
        send_item(LEVEL_TOP, 0, LEVEL_TOP);
        send_item(40000, 0, 32768);
        // primaries and the edges of the hue ramp
        send_item(0, LEVEL_ONE, 32768);
        send_item(10922, LEVEL_ONE, 32768);
        send_item(10923, LEVEL_ONE, 32768);
        send_item(21845, LEVEL_ONE, 32768);
        send_item(21846, LEVEL_ONE, 32768);
        send_item(32768, LEVEL_ONE, 32768);
        send_item(43690, LEVEL_ONE, 32768);
        send_item(43691, LEVEL_ONE, 32768);
        send_item(54613, LEVEL_ONE, 32768);
        send_item(54614, LEVEL_ONE, 32768);
        send_item(LEVEL_ONE, LEVEL_ONE, 32768);
        // hue of more than one turn, single wrap only
        send_item(98304, 50000, 30000);
        send_item(LEVEL_TOP, 50000, 30000);
        // saturation or lightness above one
        send_item(10000, LEVEL_TOP, 20000);
        send_item(10000, 40000, LEVEL_TOP);
        // either side of half lightness
        send_item(5000, 50000, 32767);
        send_item(5000, 50000, 32768);
        send_item(1, 1, 1);
        send_item(65535, 65535, 65535);
        send_item(30000, LEVEL_ONE, 0);
        send_item(30000, LEVEL_ONE, LEVEL_ONE);
        drain_pipe();

        // random colours; some chunks run without any idling
        for (chunk = 0; chunk < RANDOM_ITEMS / CHUNK_ITEMS; chunk++) begin
            quiet_run = ($urandom_range(0, 3) == 0);
            repeat (CHUNK_ITEMS)
                send_item(draw_hue(), draw_level(), draw_level());
            if (chunk == RANDOM_ITEMS / CHUNK_ITEMS / 2)
                drain_pipe();
        end
        quiet_run = 1'b0;

        // let the pipeline empty, then watch for strays before the summary
        drain_pipe();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.pending() != 0) begin
            $error("%0d rgb items never came out", board.pending());
            board.n_errors++;
        end
        $display("covered %0d colours (%0d grey, %0d with saturation or lightness over one)",
                 board.n_items, board.n_grey, board.n_over);
        $display("checked %0d rgb items, %0d mismatches", board.n_checked, board.n_errors);
        if (board.n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
